>>> hw/rtl/perlin_noise_2d_unit_macros.svh
// assertion macros for the perlin noise unit checker
`ifndef PERLIN_NOISE_2D_UNIT_MACROS_SVH
`define PERLIN_NOISE_2D_UNIT_MACROS_SVH

// checked only outside reset
`define PND_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define PND_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/pnd_pkg.sv
// shared constants for the perlin noise unit: permutation rom, port widths and valid pipeline depth
`timescale 1ns / 1ps
`default_nettype none
package pnd_pkg;

  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13,
    8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225,
    8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
    8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148,
    8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
    8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
    8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87,
    8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175,
    8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
    8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
    8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
    8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
    8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73,
    8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
    8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202,
    8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
    8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17,
    8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
    8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110,
    8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241,
    8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
    8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45,
    8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141,
    8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
  };

  localparam int COORD_W = 24;
  localparam int NOISE_W = 17;
  localparam int LATENCY = 8;

endpackage
`default_nettype wire

>>> hw/rtl/pnd_fade.sv
// three-stage quintic fade curve 6t^5-15t^4+10t^3 in fixed point
`timescale 1ns / 1ps
`default_nettype none
module pnd_fade #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [FRAC_BITS-1:0]        t,
  output logic signed [FRAC_BITS+1:0] fade
);
  localparam int F = FRAC_BITS;
  localparam logic signed [F+5:0] C15 = (F+6)'(15 * (2 ** F));
  localparam logic signed [F+5:0] C10 = (F+6)'(10 * (2 ** F));

  logic signed [F:0]     ts;
  logic signed [F+5:0]   a;
  logic signed [2*F+6:0] pa;
  logic signed [2*F+6:0] pa_sh;
  logic [2*F-1:0]        ptt;
  logic [2*F-1:0]        p3;
  logic signed [2*F+6:0] pf;
  logic signed [2*F+6:0] pf_sh;

  logic signed [F+5:0] b1;
  logic [F-1:0]        t2_1;
  logic [F-1:0]        t_1;
  logic signed [F+5:0] b2;
  logic [F-1:0]        t3_2;

  always_comb begin
    ts    = $signed({1'b0, t});
    a     = ($signed({6'b0, t}) <<< 2) + ($signed({6'b0, t}) <<< 1) - C15;
    pa    = ts * a;
    pa_sh = pa >>> F;
    ptt   = t * t;
    p3    = t2_1 * t_1;
    pf    = $signed({1'b0, t3_2}) * b2;
    pf_sh = pf >>> F;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1   <= pa_sh[F+5:0] + C10;
      t2_1 <= ptt[2*F-1:F];
      t_1  <= t;
      b2   <= b1;
      t3_2 <= p3[2*F-1:F];
      fade <= pf_sh[F+1:0];
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/pnd_hash.sv
// three-stage corner hashing and gradient selection
`timescale 1ns / 1ps
`default_nettype none
module pnd_hash #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [pnd_pkg::COORD_W-1:0] xc,
  input  logic [pnd_pkg::COORD_W-1:0] yc,
  output logic signed [FRAC_BITS+2:0] g_aa,
  output logic signed [FRAC_BITS+2:0] g_ab,
  output logic signed [FRAC_BITS+2:0] g_ba,
  output logic signed [FRAC_BITS+2:0] g_bb
);
  import pnd_pkg::*;
  localparam int F = FRAC_BITS;
  localparam logic signed [F+2:0] ONE = (F+3)'(2 ** F);

  function automatic logic signed [F+2:0] grad(
    input logic [2:0] sel,
    input logic signed [F+2:0] x,
    input logic signed [F+2:0] y
  );
    logic signed [F+2:0] u;
    logic signed [F+2:0] v;
    u = sel[2] ? y : x;
    v = sel[2] ? x : y;
    return (sel[0] ? -u : u) + (sel[1] ? -v : v);
  endfunction

  logic [COORD_W-1:0] xsh;
  logic [COORD_W-1:0] ysh;
  logic [7:0] xi;
  logic [7:0] yi;

  logic [7:0]   px0;
  logic [7:0]   px1;
  logic [7:0]   yi1;
  logic [F-1:0] xf1;
  logic [F-1:0] yf1;
  logic [7:0]   h_aa;
  logic [7:0]   h_ab;
  logic [7:0]   h_ba;
  logic [7:0]   h_bb;
  logic [F-1:0] xf2;
  logic [F-1:0] yf2;

  logic signed [F+2:0] x0;
  logic signed [F+2:0] y0;
  logic signed [F+2:0] x1;
  logic signed [F+2:0] y1;

  always_comb begin
    xsh = xc >> F;
    ysh = yc >> F;
    xi  = xsh[7:0];
    yi  = ysh[7:0];
    x0  = $signed({3'b0, xf2});
    y0  = $signed({3'b0, yf2});
    x1  = x0 - ONE;
    y1  = y0 - ONE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px0  <= PERM[xi];
      px1  <= PERM[8'(xi + 8'd1)];
      yi1  <= yi;
      xf1  <= xc[F-1:0];
      yf1  <= yc[F-1:0];
      h_aa <= PERM[8'(px0 + yi1)];
      h_ab <= PERM[8'(px0 + yi1 + 8'd1)];
      h_ba <= PERM[8'(px1 + yi1)];
      h_bb <= PERM[8'(px1 + yi1 + 8'd1)];
      xf2  <= xf1;
      yf2  <= yf1;
      g_aa <= grad(h_aa[2:0], x0, y0);
      g_ab <= grad(h_ab[2:0], x0, y1);
      g_ba <= grad(h_ba[2:0], x1, y0);
      g_bb <= grad(h_bb[2:0], x1, y1);
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/pnd_lerp.sv
// four-stage bilinear blend, output scaling and clamp
`timescale 1ns / 1ps
`default_nettype none
module pnd_lerp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [FRAC_BITS+1:0] u,
  input  logic signed [FRAC_BITS+1:0] v,
  input  logic signed [FRAC_BITS+2:0] g_aa,
  input  logic signed [FRAC_BITS+2:0] g_ab,
  input  logic signed [FRAC_BITS+2:0] g_ba,
  input  logic signed [FRAC_BITS+2:0] g_bb,
  output logic [pnd_pkg::NOISE_W-1:0] noise_value
);
  import pnd_pkg::*;
  localparam int F = FRAC_BITS;
  localparam int SHR = (F >= 15) ? F - 15 : 0;
  localparam int SHL = (F >= 15) ? 0 : 15 - F;
  localparam logic signed [F+6:0] ONE = (F+7)'(2 ** F);
  localparam logic signed [31:0] RMAX = 32'sd65536;

  logic signed [F+3:0]   da;
  logic signed [F+3:0]   db;
  logic signed [2*F+5:0] pa;
  logic signed [2*F+5:0] pb;
  logic signed [2*F+5:0] pa_sh;
  logic signed [2*F+5:0] pb_sh;
  logic signed [F+5:0]   d2;
  logic signed [2*F+7:0] p2;
  logic signed [2*F+7:0] p2_sh;
  logic signed [F+6:0]   q;
  logic signed [31:0]    qe;
  logic signed [31:0]    r;

  logic signed [F+3:0] pa1;
  logic signed [F+3:0] pb1;
  logic signed [F+2:0] ga1;
  logic signed [F+2:0] gb1;
  logic signed [F+1:0] v1;
  logic signed [F+4:0] x1;
  logic signed [F+4:0] x2;
  logic signed [F+1:0] v2;
  logic signed [F+5:0] p3;
  logic signed [F+4:0] x1_3;

  always_comb begin
    da    = g_ba - g_aa;
    db    = g_bb - g_ab;
    pa    = u * da;
    pb    = u * db;
    pa_sh = pa >>> F;
    pb_sh = pb >>> F;
    d2    = x2 - x1;
    p2    = v2 * d2;
    p2_sh = p2 >>> F;
    q     = x1_3 + p3 + ONE;
    qe    = 32'(q);
    r     = (qe >>> SHR) <<< SHL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa1  <= pa_sh[F+3:0];
      pb1  <= pb_sh[F+3:0];
      ga1  <= g_aa;
      gb1  <= g_ab;
      v1   <= v;
      x1   <= ga1 + pa1;
      x2   <= gb1 + pb1;
      v2   <= v1;
      p3   <= p2_sh[F+5:0];
      x1_3 <= x1;
      if (r < 0) begin
        noise_value <= '0;
      end else if (r > RMAX) begin
        noise_value <= NOISE_W'(RMAX);
      end else begin
        noise_value <= r[NOISE_W-1:0];
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/perlin_noise_2d_unit.sv
// 2d gradient noise unit: top level with input register and valid pipeline
//
// sample channel: sample_valid/sample_ready carry x_coord and y_coord,
// unsigned fixed point with FRAC_BITS fraction bits; the integer part
// wraps modulo 256.
// noise channel: noise_valid/noise_ready carry noise_value, unsigned
// q1.16 in 0..65536.
// one sample enters per cycle unless the output stalls; its result passes
// eight register stages: an input register, three stages of fade and
// corner hashing, and four stages of blending and scaling. the fade and
// blend multipliers, each followed by a register, set the stage count.
// sustained throughput is one item per cycle while noise_ready is high.
// the whole pipeline advances together; while noise_valid is high and
// noise_ready is low, every stage holds and sample_ready is low, so
// nothing is lost or repeated. no other state is kept.
// reset (rst, synchronous) clears all valid bits; data registers are not
// reset.
`timescale 1ns / 1ps
`default_nettype none
module perlin_noise_2d_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic [pnd_pkg::COORD_W-1:0] x_coord,
  input  logic [pnd_pkg::COORD_W-1:0] y_coord,
  output logic                        noise_valid,
  input  logic                        noise_ready,
  output logic [pnd_pkg::NOISE_W-1:0] noise_value
);
  import pnd_pkg::*;
  localparam int F = FRAC_BITS;

  logic                 en;
  logic [LATENCY-1:0]   vld;
  logic [LATENCY-1:0]   vld_next;
  logic [COORD_W-1:0]   xc0;
  logic [COORD_W-1:0]   yc0;
  logic signed [F+1:0]  fade_u;
  logic signed [F+1:0]  fade_v;
  logic signed [F+2:0]  g_aa;
  logic signed [F+2:0]  g_ab;
  logic signed [F+2:0]  g_ba;
  logic signed [F+2:0]  g_bb;

  assign en           = !vld[LATENCY-1] || noise_ready;
  assign sample_ready = en;
  assign noise_valid  = vld[LATENCY-1];
  assign vld_next     = {vld[LATENCY-2:0], sample_valid && sample_ready};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xc0 <= x_coord;
      yc0 <= y_coord;
    end
  end

  pnd_fade #(.FRAC_BITS(F)) u_fade_x (
    .clk  (clk),
    .en   (en),
    .t    (xc0[F-1:0]),
    .fade (fade_u)
  );

  pnd_fade #(.FRAC_BITS(F)) u_fade_y (
    .clk  (clk),
    .en   (en),
    .t    (yc0[F-1:0]),
    .fade (fade_v)
  );

  pnd_hash #(.FRAC_BITS(F)) u_hash (
    .clk  (clk),
    .en   (en),
    .xc   (xc0),
    .yc   (yc0),
    .g_aa (g_aa),
    .g_ab (g_ab),
    .g_ba (g_ba),
    .g_bb (g_bb)
  );

  pnd_lerp #(.FRAC_BITS(F)) u_lerp (
    .clk         (clk),
    .en          (en),
    .u           (fade_u),
    .v           (fade_v),
    .g_aa        (g_aa),
    .g_ab        (g_ab),
    .g_ba        (g_ba),
    .g_bb        (g_bb),
    .noise_value (noise_value)
  );
endmodule
`default_nettype wire

>>> hw/rtl/pnd_checker.sv
// port-level checker for the perlin noise unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "perlin_noise_2d_unit_macros.svh"
module pnd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        sample_valid,
  input logic                        sample_ready,
  input logic [pnd_pkg::COORD_W-1:0] x_coord,
  input logic [pnd_pkg::COORD_W-1:0] y_coord,
  input logic                        noise_valid,
  input logic                        noise_ready,
  input logic [pnd_pkg::NOISE_W-1:0] noise_value
);
  import pnd_pkg::*;

  logic coord_seen;
  assign coord_seen = ^{x_coord, y_coord, sample_valid} || 1'b1;

  `PND_ASSERT_ALWAYS(a_reset_empty, rst |=> !noise_valid, "result valid right after reset")
  `PND_ASSERT(a_value_range, noise_valid && coord_seen |-> noise_value <= 17'd65536, "noise out of range")
  `PND_ASSERT(a_stall_blocks, noise_valid && !noise_ready |-> !sample_ready, "item taken while output stalled")
  `PND_ASSERT(a_out_hold, noise_valid && !noise_ready |=> noise_valid && $stable(noise_value), "stalled result changed")
endmodule

bind perlin_noise_2d_unit pnd_checker u_pnd_checker (.*);
`default_nettype wire
